/* sv/fcir_pkg.sv */
// ----------------------------------------------------------------------------
// fcir_pkg
// Types, codes and helpers shared by the forwarded client address resolver.
// ----------------------------------------------------------------------------
package fcir_pkg;

  localparam int unsigned V4_BITS = 32;
  localparam int unsigned V6_BITS = 128;

  // Byte address of the range_count register.
  localparam logic [2:0] REG_RANGE_COUNT = 3'd0;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_PEER  = 2'd1,
    FUNC_ENTRY = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_PEER_UNTRUSTED = 2'd0,
    STAT_FROM_CHAIN     = 2'd1,
    STAT_CHAIN_REJECTED = 2'd2,
    STAT_NO_CHAIN       = 2'd3
  } status_e;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        v4;
  } addr_t;

  typedef struct packed {
    func_e       func;
    logic [3:0]  slot;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic        is_v4;
    logic [7:0]  prefix_len;
    logic        entry_bad;
    logic        last;
  } in_item_t;

  typedef struct packed {
    addr_t   addr;
    status_e status;
  } result_t;

  // IPv4 keeps only the low 32 bits of the low word.
  function automatic addr_t norm_addr(logic [63:0] hi, logic [63:0] lo, logic v4);
    addr_t a;
    a.v4 = v4;
    a.hi = v4 ? 64'd0 : hi;
    a.lo = v4 ? {32'd0, lo[31:0]} : lo;
    return a;
  endfunction

  // Network mask over {hi, lo}; long prefixes saturate to the family width.
  function automatic logic [127:0] range_mask(logic [7:0] plen, logic v4);
    logic [31:0]  m4;
    logic [127:0] m6;
    m4 = ~(32'hffff_ffff >> plen);
    m6 = ~({V6_BITS{1'b1}} >> plen);
    return v4 ? {96'd0, m4} : m6;
  endfunction

endpackage

/* sv/fcir_range_table.sv */
// ----------------------------------------------------------------------------
// fcir_range_table
// Trusted CIDR range slots with a parallel masked compare of one address.
// ----------------------------------------------------------------------------
module fcir_range_table import fcir_pkg::*; #(
  parameter int unsigned RANGE_SLOTS = 16
) (
  input  logic       clk_i,
  input  logic       wr_en_i,
  input  logic [3:0] wr_slot_i,
  input  addr_t      wr_addr_i,
  input  logic [7:0] wr_plen_i,
  input  logic [4:0] range_count_i,
  input  addr_t      query_i,
  output logic       trusted_o
);

  // Each slot holds its network already masked, plus the mask itself.
  logic [127:0] net_q  [RANGE_SLOTS];
  logic [127:0] mask_q [RANGE_SLOTS];
  logic         fam_q  [RANGE_SLOTS];
  logic [RANGE_SLOTS-1:0] hit;
  logic [127:0] wr_mask;

  assign wr_mask = range_mask(wr_plen_i, wr_addr_i.v4);

  for (genvar s = 0; s < RANGE_SLOTS; s++) begin : g_slot
    always_ff @(posedge clk_i) begin
      if (wr_en_i && (int'(wr_slot_i) == s)) begin
        net_q[s]  <= {wr_addr_i.hi, wr_addr_i.lo} & wr_mask;
        mask_q[s] <= wr_mask;
        fam_q[s]  <= wr_addr_i.v4;
      end
    end

    assign hit[s] = (int'(range_count_i) > s) && (fam_q[s] == query_i.v4) &&
                    ((({query_i.hi, query_i.lo}) & mask_q[s]) == net_q[s]);
  end

  assign trusted_o = |hit;

endmodule

/* sv/fcir_chain.sv */
// ----------------------------------------------------------------------------
// fcir_chain
// Peer and forwarded-chain tracking; forms the resolved address of a request.
// ----------------------------------------------------------------------------
module fcir_chain import fcir_pkg::*; #(
  parameter int unsigned CHAIN_LIMIT = 64
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  func_e   func_i,
  input  addr_t   addr_i,
  input  logic    bad_i,
  input  logic    last_i,
  input  logic    trusted_i,
  output result_t result_o
);

  localparam int unsigned CNT_W = $clog2(CHAIN_LIMIT + 1);

  addr_t            peer_q, peer_d;
  logic             peer_trusted_q, peer_trusted_d;
  addr_t            first_q, first_d;
  addr_t            untr_q, untr_d;
  logic             untr_seen_q, untr_seen_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             rejected_q, rejected_d;

  always_comb begin
    peer_d         = peer_q;
    peer_trusted_d = peer_trusted_q;
    first_d        = first_q;
    untr_d         = untr_q;
    untr_seen_d    = untr_seen_q;
    count_d        = count_q;
    rejected_d     = rejected_q;

    if (step_i) begin
      if (func_i == FUNC_PEER) begin
        peer_d         = addr_i;
        peer_trusted_d = trusted_i;
        untr_seen_d    = 1'b0;
        count_d        = '0;
        rejected_d     = 1'b0;
      end else if (!rejected_q && (count_q < CNT_W'(CHAIN_LIMIT))) begin
        if (bad_i) begin
          rejected_d = 1'b1;
        end else begin
          if (count_q == '0) begin
            first_d = addr_i;
          end else if (!trusted_i) begin
            untr_d      = addr_i;
            untr_seen_d = 1'b1;
          end
          count_d = count_q + CNT_W'(1);
        end
      end
    end

    // The result sees this item's own update.
    result_o.addr = peer_d;
    if (!peer_trusted_d) begin
      result_o.status = STAT_PEER_UNTRUSTED;
    end else if (rejected_d) begin
      result_o.status = STAT_CHAIN_REJECTED;
    end else if (count_d == '0) begin
      result_o.status = STAT_NO_CHAIN;
    end else begin
      result_o.status = STAT_FROM_CHAIN;
      result_o.addr   = untr_seen_d ? untr_d : first_d;
    end

    // A delivered result closes the chain; the peer stays.
    if (step_i && last_i) begin
      untr_seen_d = 1'b0;
      count_d     = '0;
      rejected_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peer_q         <= '0;
      peer_trusted_q <= 1'b0;
      first_q        <= '0;
      untr_q         <= '0;
      untr_seen_q    <= 1'b0;
      count_q        <= '0;
      rejected_q     <= 1'b0;
    end else begin
      peer_q         <= peer_d;
      peer_trusted_q <= peer_trusted_d;
      first_q        <= first_d;
      untr_q         <= untr_d;
      untr_seen_q    <= untr_seen_d;
      count_q        <= count_d;
      rejected_q     <= rejected_d;
    end
  end

endmodule

/* sv/forwarded_client_ip_resolver.sv */
// ----------------------------------------------------------------------------
// forwarded_client_ip_resolver
// Resolves the client address of a request from its peer and forwarded chain
// against a table of trusted CIDR ranges.
//
//   channel   direction  carries
//   s_axis    in         load, peer and chain-entry items (func in tuser)
//   m_axis    out        one resolved address per request (status in tuser)
//   apb       in/out     range_count register at byte address 0
//
// One item is taken per cycle unless the output stalls. An item sits in the
// input register, where the range compare and chain update run, and a result
// then sits in the output register.
// Reset clears the request state and range_count; table slots are undefined
// until loaded. A stalled output only holds back an item that closes a request.
// ----------------------------------------------------------------------------
module forwarded_client_ip_resolver import fcir_pkg::*; #(
  parameter int unsigned RANGE_SLOTS = 16,
  parameter int unsigned CHAIN_LIMIT = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // slot[3:0], addr_hi[67:4], addr_lo[131:68], is_v4[132], prefix_len[140:133],
  // entry_bad[141], zero fill[143:142]
  input  logic [143:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  // func[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // client_hi[63:0], client_lo[127:64], client_v4[128], zero fill[135:129]
  output logic [135:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]   m_axis_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [4:0] range_count_q;
  logic       in_valid_q;
  in_item_t   in_q;
  logic       out_valid_q;
  result_t    out_q;
  addr_t      addr_n;
  logic       is_req, emit, out_free, fire, trusted;
  result_t    result;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RANGE_COUNT[2]) ? {27'd0, range_count_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_count_q <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_RANGE_COUNT[2])) begin
      range_count_q <= pwdata[4:0];
    end
  end

  // Input register.
  assign is_req        = (in_q.func == FUNC_PEER) || (in_q.func == FUNC_ENTRY);
  assign emit          = is_req && in_q.last;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && (!emit || out_free);
  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.func       <= func_e'(s_axis_tuser);
      in_q.slot       <= s_axis_tdata[3:0];
      in_q.addr_hi    <= s_axis_tdata[67:4];
      in_q.addr_lo    <= s_axis_tdata[131:68];
      in_q.is_v4      <= s_axis_tdata[132];
      in_q.prefix_len <= s_axis_tdata[140:133];
      in_q.entry_bad  <= s_axis_tdata[141];
      in_q.last       <= s_axis_tlast;
    end
  end

  assign addr_n = norm_addr(in_q.addr_hi, in_q.addr_lo, in_q.is_v4);

  fcir_range_table #(
    .RANGE_SLOTS(RANGE_SLOTS)
  ) u_table (
    .clk_i        (clk_i),
    .wr_en_i      (fire && (in_q.func == FUNC_LOAD)),
    .wr_slot_i    (in_q.slot),
    .wr_addr_i    (addr_n),
    .wr_plen_i    (in_q.prefix_len),
    .range_count_i(range_count_q),
    .query_i      (addr_n),
    .trusted_o    (trusted)
  );

  fcir_chain #(
    .CHAIN_LIMIT(CHAIN_LIMIT)
  ) u_chain (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (fire && is_req),
    .func_i   (in_q.func),
    .addr_i   (addr_n),
    .bad_i    (in_q.entry_bad),
    .last_i   (in_q.last),
    .trusted_i(trusted),
    .result_o (result)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_q.addr.v4, out_q.addr.lo, out_q.addr.hi};
  assign m_axis_tuser  = out_q.status;

endmodule

/* sv/fcir_checker.sv */
// ----------------------------------------------------------------------------
// fcir_checker
// Port-level checks on the forwarded client address resolver.
// ----------------------------------------------------------------------------
module fcir_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [135:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  // A result waiting on the output holds still.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // With the output register empty, the input side never stalls.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // An IPv4 result has a zero upper word.
  a_v4_hi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[128] |-> (m_axis_tdata[63:0] == 64'd0))
    else $error("IPv4 result with nonzero upper word");

  // An IPv4 result uses only the low 32 bits of the lower word.
  a_v4_lo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[128] |-> (m_axis_tdata[127:96] == 32'd0))
    else $error("IPv4 result with bits above 32");

endmodule

bind forwarded_client_ip_resolver fcir_checker u_fcir_checker (.*);

/* test/forwarded_client_ip_resolver_tb.sv */
// ----------------------------------------------------------------------------
// forwarded_client_ip_resolver_tb
// Self-checking bench for the forwarded client address resolver. Loads the
// trusted range table, sends directed and random requests (peer plus chain
// entries) under several range_count settings and flow-control patterns, and
// compares every resolved address against a cycle-free prediction.
// ----------------------------------------------------------------------------
module forwarded_client_ip_resolver_tb import fcir_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = 16;
  localparam int unsigned CHAIN_MAX = 64;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned MAX_GAP = 200;

  // Tracks the trusted range table and the request state, and holds the
  // resolved addresses still owed by the block.
  class resolver_scoreboard;
    logic [63:0] net_hi[SLOTS];
    logic [63:0] net_lo[SLOTS];
    logic [7:0]  net_plen[SLOTS];
    logic        net_v4[SLOTS];
    logic [4:0]  slots_used;
    addr_t       peer;
    bit          peer_ok;
    addr_t       first_ent;
    addr_t       last_untrusted;
    bit          untrusted_seen;
    int unsigned chain_len;
    bit          rejected;
    result_t     pending[$];
    int unsigned mismatches;

    function new();
      for (int s = 0; s < SLOTS; s++) begin
        net_hi[s] = '0;
        net_lo[s] = '0;
        net_plen[s] = '0;
        net_v4[s] = 1'b0;
      end
      slots_used = '0;
      peer = '0;
      peer_ok = 1'b0;
      mismatches = 0;
      clear_chain();
    endfunction

    static function logic [127:0] prefix_mask(logic [7:0] p, logic v4);
      if (p == 0) return '0;
      if (v4) return {96'd0, 32'hffff_ffff << (32 - p)};
      return {128{1'b1}} << (128 - p);
    endfunction

    function int unsigned active_slots();
      return (slots_used > SLOTS) ? SLOTS : slots_used;
    endfunction

    function void set_range_count(logic [4:0] v);
      slots_used = v;
    endfunction

    function bit addr_trusted(addr_t a);
      logic [127:0] m;
      for (int s = 0; s < active_slots(); s++) begin
        if (net_v4[s] != a.v4) continue;
        m = prefix_mask(net_plen[s], a.v4);
        if ((({net_hi[s], net_lo[s]} ^ {a.hi, a.lo}) & m) == '0) return 1'b1;
      end
      return 1'b0;
    endfunction

    function void clear_chain();
      first_ent = '0;
      last_untrusted = '0;
      untrusted_seen = 1'b0;
      chain_len = 0;
      rejected = 1'b0;
    endfunction

    function void note_item(in_item_t it);
      addr_t   a;
      result_t r;
      a.v4 = it.is_v4;
      a.hi = it.is_v4 ? 64'd0 : it.addr_hi;
      a.lo = it.is_v4 ? {32'd0, it.addr_lo[31:0]} : it.addr_lo;
      case (it.func)
        FUNC_LOAD: begin
          net_hi[it.slot] = a.hi;
          net_lo[it.slot] = a.lo;
          net_v4[it.slot] = a.v4;
          if (a.v4) net_plen[it.slot] = (it.prefix_len > 32) ? 8'd32 : it.prefix_len;
          else net_plen[it.slot] = (it.prefix_len > 128) ? 8'd128 : it.prefix_len;
          return;
        end
        FUNC_NONE: return;
        FUNC_PEER: begin
          peer = a;
          peer_ok = addr_trusted(a);
          clear_chain();
        end
        default: begin
          if (!rejected && chain_len < CHAIN_MAX) begin
            if (it.entry_bad) begin
              rejected = 1'b1;
            end else begin
              if (chain_len == 0) begin
                first_ent = a;
              end else if (!addr_trusted(a)) begin
                last_untrusted = a;
                untrusted_seen = 1'b1;
              end
              chain_len++;
            end
          end
        end
      endcase
      if (!it.last) return;
      r.addr = peer;
      if (!peer_ok) begin
        r.status = STAT_PEER_UNTRUSTED;
      end else if (rejected) begin
        r.status = STAT_CHAIN_REJECTED;
      end else if (chain_len == 0) begin
        r.status = STAT_NO_CHAIN;
      end else begin
        r.status = STAT_FROM_CHAIN;
        r.addr = untrusted_seen ? last_untrusted : first_ent;
      end
      pending = {pending, r};
      clear_chain();
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: hi %h lo %h v4 %0d status %0d",
                   got.addr.hi, got.addr.lo, got.addr.v4, got.status);
        return;
      end
      want = pending.pop_front();
      if (got.addr.hi !== want.addr.hi || got.addr.lo !== want.addr.lo ||
          got.addr.v4 !== want.addr.v4 || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch: expected hi %h lo %h v4 %0d status %0d",
                   want.addr.hi, want.addr.lo, want.addr.v4, want.status);
          $display("                 got      hi %h lo %h v4 %0d status %0d",
                   got.addr.hi, got.addr.lo, got.addr.v4, got.status);
        end
      end
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  resolver_scoreboard sb;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;

  forwarded_client_ip_resolver dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Accepted items and results are taken from the values present before the edge.
  always @(posedge clk_i) begin : monitor
    in_item_t seen;
    result_t  got;
    if (s_axis_tvalid && s_axis_tready) begin
      seen.slot       = s_axis_tdata[3:0];
      seen.addr_hi    = s_axis_tdata[67:4];
      seen.addr_lo    = s_axis_tdata[131:68];
      seen.is_v4      = s_axis_tdata[132];
      seen.prefix_len = s_axis_tdata[140:133];
      seen.entry_bad  = s_axis_tdata[141];
      seen.func       = func_e'(s_axis_tuser);
      seen.last       = s_axis_tlast;
      sb.note_item(seen);
    end
    if (m_axis_tvalid && m_axis_tready) begin
      got.addr.hi = m_axis_tdata[63:0];
      got.addr.lo = m_axis_tdata[127:64];
      got.addr.v4 = m_axis_tdata[128];
      got.status  = status_e'(m_axis_tuser);
      sb.check_result(got);
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Every field but func and last gets random content; last starts clear.
  function automatic in_item_t blank_item(func_e f);
    in_item_t it;
    it.func       = f;
    it.slot       = 4'($urandom_range(15));
    it.addr_hi    = {$urandom, $urandom};
    it.addr_lo    = {$urandom, $urandom};
    it.is_v4      = 1'($urandom_range(1));
    it.prefix_len = 8'($urandom_range(255));
    it.entry_bad  = 1'($urandom_range(1));
    it.last       = 1'b0;
    return it;
  endfunction

  // With a slot given, the address falls inside that slot's range; the bits
  // outside the prefix (and the unused upper bits of an IPv4 item) are random.
  function automatic in_item_t with_addr(in_item_t it, int s);
    logic [127:0] r;
    logic [127:0] m;
    r = {$urandom, $urandom, $urandom, $urandom};
    if (s >= 0) begin
      it.is_v4 = sb.net_v4[s];
      m = resolver_scoreboard::prefix_mask(sb.net_plen[s], sb.net_v4[s]);
      r = ({sb.net_hi[s], sb.net_lo[s]} & m) | (r & ~m);
    end else begin
      it.is_v4 = 1'($urandom_range(1));
    end
    it.addr_hi = r[127:64];
    it.addr_lo = r[63:0];
    return it;
  endfunction

  function automatic int used_slot();
    int unsigned n;
    n = sb.active_slots();
    if (n == 0) return -1;
    return $urandom_range(n - 1);
  endfunction

  function automatic logic [7:0] rand_prefix(logic v4);
    int unsigned k;
    k = $urandom_range(99);
    if (k < 3) return 8'd0;
    if (k < 8) return 8'($urandom_range(1, 7));
    if (k < 18) return 8'($urandom_range(v4 ? 33 : 129, 255));
    return v4 ? 8'($urandom_range(8, 32)) : 8'($urandom_range(16, 128));
  endfunction

  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {2'b00, it.entry_bad, it.prefix_len, it.is_v4, it.addr_lo,
                      it.addr_hi, it.slot};
    s_axis_tuser  <= it.func;
    s_axis_tlast  <= it.last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic load_range(input logic [3:0] slot, input logic v4,
                            input logic [63:0] hi, input logic [63:0] lo,
                            input logic [7:0] plen);
    in_item_t it;
    it = blank_item(FUNC_LOAD);
    it.slot = slot;
    it.is_v4 = v4;
    it.addr_hi = hi;
    it.addr_lo = lo;
    it.prefix_len = plen;
    it.last = 1'($urandom_range(1));
    send_item(it);
  endtask

  task automatic load_random(input logic [3:0] slot);
    logic v4;
    v4 = 1'($urandom_range(1));
    load_range(slot, v4, {$urandom, $urandom}, {$urandom, $urandom}, rand_prefix(v4));
  endtask

  task automatic send_addr(input func_e f, input int s, input logic bad,
                           input logic last);
    in_item_t it;
    it = with_addr(blank_item(f), s);
    it.entry_bad = bad;
    it.last = last;
    send_item(it);
  endtask

  // Lets every owed result come back, then the block drain its pipeline.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_range_count(data[4:0]);
  endtask

  task automatic random_action();
    int unsigned pick;
    int unsigned n;
    in_item_t    it;
    pick = $urandom_range(99);
    if (pick < 8) begin
      load_random(4'($urandom_range(15)));
    end else if (pick < 12) begin
      it = blank_item(FUNC_NONE);
      it.last = 1'($urandom_range(1));
      send_item(it);
    end else if (pick < 17) begin
      // Entries with no peer item join a chain against the stored peer.
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++)
        send_addr(FUNC_ENTRY, ($urandom_range(99) < 60) ? used_slot() : -1,
                  ($urandom_range(99) < 3), i == n - 1);
    end else begin
      pick = $urandom_range(99);
      if (pick < 20) n = 0;
      else if (pick < 91) n = $urandom_range(1, 6);
      else if (pick < 98) n = $urandom_range(7, 20);
      else n = $urandom_range(65, 70);
      send_addr(FUNC_PEER, ($urandom_range(99) < 75) ? used_slot() : -1,
                1'($urandom_range(1)), n == 0);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(99) < 3) load_random(4'($urandom_range(15)));
        send_addr(FUNC_ENTRY, ($urandom_range(99) < 60) ? used_slot() : -1,
                  ($urandom_range(99) < 3), i == n - 1);
      end
    end
  endtask

  task automatic run_segment(input logic [4:0] count, input int unsigned send_idle,
                             input int unsigned recv_stall, input int unsigned n);
    int unsigned start;
    bit          paused;
    settle();
    apb_write(REG_RANGE_COUNT, {27'd0, count});
    idle_pct = send_idle;
    stall_pct = recv_stall;
    start = items_sent;
    paused = 1'b0;
    while (items_sent - start < n) begin
      random_action();
      if (!paused && items_sent - start >= n / 2) begin
        settle();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every slot is loaded before any slot is put in use.
    load_range(4'd0, 1'b1, 64'hffff_ffff_ffff_ffff, 64'hdead_beef_0a00_0000, 8'd8);
    load_range(4'd1, 1'b1, 64'h0, 64'h0000_0000_c0a8_0107, 8'hff);
    load_range(4'd2, 1'b0, 64'h2001_0db8_0000_0000, {$urandom, $urandom}, 8'd32);
    load_range(4'd3, 1'b0, {$urandom, $urandom}, {$urandom, $urandom}, 8'd200);
    load_range(4'd4, 1'b0, {$urandom, $urandom}, {$urandom, $urandom}, 8'd64);
    load_range(4'd5, 1'b0, {$urandom, $urandom}, {$urandom, $urandom}, 8'd100);
    load_range(4'd6, 1'b1, {$urandom, $urandom}, {$urandom, $urandom}, 8'd33);
    for (int s = 7; s < SLOTS; s++) load_random(4'(s));
    settle();
    apb_write(REG_RANGE_COUNT, 32'd16);

    begin : directed
      in_item_t it;
      // Untrusted IPv6 peer with every other field at its maximum.
      it = '1;
      it.func = FUNC_PEER;
      it.is_v4 = 1'b0;
      send_item(it);
      // Trusted IPv4 peer with junk in the unused upper bits, no chain.
      it = with_addr(blank_item(FUNC_PEER), 0);
      it.addr_hi = '1;
      it.last = 1'b1;
      send_item(it);
      // All entries after the first trusted: the first entry is returned.
      send_addr(FUNC_PEER, 1, 1'b0, 1'b0);
      it = '0;
      it.func = FUNC_ENTRY;
      send_item(it);
      send_addr(FUNC_ENTRY, 2, 1'b0, 1'b0);
      send_addr(FUNC_ENTRY, 5, 1'b0, 1'b1);
      // Rightmost untrusted entry wins.
      send_addr(FUNC_PEER, 3, 1'b0, 1'b0);
      send_addr(FUNC_ENTRY, -1, 1'b0, 1'b0);
      send_addr(FUNC_ENTRY, -1, 1'b0, 1'b0);
      send_addr(FUNC_ENTRY, 4, 1'b0, 1'b1);
      // Malformed entry rejects the chain; later entries are ignored.
      send_addr(FUNC_PEER, 0, 1'b0, 1'b0);
      send_addr(FUNC_ENTRY, 6, 1'b0, 1'b0);
      send_addr(FUNC_ENTRY, -1, 1'b1, 1'b0);
      send_addr(FUNC_ENTRY, -1, 1'b0, 1'b1);
      // Untrusted peer wins over a bad chain.
      send_addr(FUNC_PEER, -1, 1'b0, 1'b0);
      send_addr(FUNC_ENTRY, -1, 1'b1, 1'b1);
      // A bad flag on the peer item is ignored.
      send_addr(FUNC_PEER, 2, 1'b1, 1'b0);
      send_addr(FUNC_ENTRY, -1, 1'b0, 1'b1);
      // Unused function code with last set and a load give no result.
      it = '1;
      it.func = FUNC_NONE;
      send_item(it);
      load_range(4'd15, 1'b1, '1, '1, 8'd0);
      // A zero prefix trusts every IPv4 address, then an entry with no peer.
      send_addr(FUNC_PEER, -1, 1'b0, 1'b1);
      send_addr(FUNC_ENTRY, -1, 1'b0, 1'b1);
      load_random(4'd15);
    end

    run_segment(5'd16, 0, 0, 260);
    run_segment(5'd31, 78, 0, 200);
    run_segment(5'd3, 0, 78, 220);
    run_segment(5'd0, 8, 8, 80);
    run_segment(5'd12, 8, 8, 340);

    settle();
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
